### rtl/acc_pkg.sv
// ----------------------------------------------------------------------------
// acc_pkg
// Shared constants, types and helper functions for the box/circle contact
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

   localparam int MASK_BITS = 32;
   localparam logic [31:0] MASK_LOW = 32'((64'd1 << MASK_BITS) - 64'd1);

   localparam int SQRT_STAGES = 31;
   localparam int QUO_BITS    = 17;

   localparam logic KIND_COLL = 1'b0;
   localparam logic KIND_TRIG = 1'b1;

   localparam logic signed [17:0] NORM_MAX = 18'sd65536;

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic [30:0]        mag_x;
      logic [30:0]        mag_y;
      logic [30:0]        radius;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               coll;
      logic [31:0]        trig_mask;
      logic [31:0]        tag;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sh0_7FFF_FFFF;
      lo = -34'sh0_8000_0000;
      if (v > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

### rtl/acc_isqrt.sv
// ----------------------------------------------------------------------------
// acc_isqrt
// Pipelined integer square root of a 62-bit value, one result bit per stage,
// with the item's side data carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [61:0]       in_value,
   input  acc_pkg::side_type in_side,
   output logic              out_valid,
   output logic [30:0]       out_root,
   output acc_pkg::side_type out_side
);
   import acc_pkg::*;

   logic        vld_ff  [SQRT_STAGES];
   logic [32:0] rem_ff  [SQRT_STAGES];
   logic [30:0] root_ff [SQRT_STAGES];
   logic [61:0] val_ff  [SQRT_STAGES];
   side_type    side_ff [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
      logic        vld_p;
      logic [32:0] rem_p;
      logic [30:0] root_p;
      logic [61:0] val_p;
      side_type    side_p;
      logic [34:0] trial;
      logic [34:0] test;
      logic [32:0] rem_in;
      logic [30:0] root_in;

      if (i == 0) begin : g_first
         assign vld_p  = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign val_p  = in_value;
         assign side_p = in_side;
      end else begin : g_next
         assign vld_p  = vld_ff[i-1];
         assign rem_p  = rem_ff[i-1];
         assign root_p = root_ff[i-1];
         assign val_p  = val_ff[i-1];
         assign side_p = side_ff[i-1];
      end

      always_comb begin
         trial = {rem_p, val_p[61:60]};
         test  = {2'b00, root_p, 2'b01};
         if (trial >= test) begin
            rem_in  = 33'(trial - test);
            root_in = {root_p[29:0], 1'b1};
         end else begin
            rem_in  = trial[32:0];
            root_in = {root_p[29:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= vld_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            val_ff[i]  <= {val_p[59:0], 2'b00};
            side_ff[i] <= side_p;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

### rtl/acc_ndiv.sv
// ----------------------------------------------------------------------------
// acc_ndiv
// Pipelined restoring divider for both normal components: rounded
// magnitude * 65536 / distance, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_ndiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [30:0]       in_root,
   input  acc_pkg::side_type in_side,
   output logic              out_valid,
   output logic [30:0]       out_root,
   output logic [16:0]       out_quo_x,
   output logic [16:0]       out_quo_y,
   output acc_pkg::side_type out_side
);
   import acc_pkg::*;

   localparam int NS = QUO_BITS + 1;

   logic        vld_ff  [NS];
   logic [30:0] root_ff [NS];
   side_type    side_ff [NS];
   logic [46:0] remx_ff [NS];
   logic [46:0] remy_ff [NS];
   logic [16:0] qx_ff   [NS];
   logic [16:0] qy_ff   [NS];

   function automatic logic [47:0] div_step(input logic [46:0] rem, input logic [30:0] d,
                                            input int k);
      logic [47:0] dsh;
      logic [47:0] r48;
      dsh = 48'(d) << k;
      r48 = {1'b0, rem};
      if (r48 >= dsh) begin
         return {1'b1, 47'(r48 - dsh)};
      end
      return {1'b0, rem};
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff[0] <= in_root;
         side_ff[0] <= in_side;
         remx_ff[0] <= {in_side.mag_x, 16'h0000} + 47'(in_root >> 1);
         remy_ff[0] <= {in_side.mag_y, 16'h0000} + 47'(in_root >> 1);
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_stage
      localparam int K = QUO_BITS - s;
      logic [47:0] stx;
      logic [47:0] sty;

      assign stx = div_step(remx_ff[s-1], root_ff[s-1], K);
      assign sty = div_step(remy_ff[s-1], root_ff[s-1], K);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[s] <= root_ff[s-1];
            side_ff[s] <= side_ff[s-1];
            remx_ff[s] <= stx[46:0];
            remy_ff[s] <= sty[46:0];
            qx_ff[s]   <= {qx_ff[s-1][15:0], stx[47]};
            qy_ff[s]   <= {qy_ff[s-1][15:0], sty[47]};
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_quo_x = qx_ff[NS-1];
   assign out_quo_y = qy_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire

### rtl/aabb_circle_contact.sv
// ----------------------------------------------------------------------------
// aabb_circle_contact
// Contact test between an axis-aligned box and a circle in Q16.16, giving a
// collision event and/or a trigger event per touching pair, as the masks allow.
//
//   Channel | Ports  | Direction | Moves
//   --------+--------+-----------+-------------------------------------
//   request | req_*  | in        | one box/circle pair per item
//   result  | rsp_*  | out       | one collision or trigger event per item
//
// A pair is taken every cycle unless the pipeline is stalled.
// A pair with both events holds the output register for its collision event
// and then its trigger event, stalling the pipeline while the collision is held.
// Most of the depth is in the square root (31 stages) and the divider (18 stages).
// Reset is synchronous and clears only the valid bits and the output event flags.
// A stall on the result channel while an event is held freezes every stage and stalls the request.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_circle_contact (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_box_center_x,
   input  logic signed [31:0] req_box_center_y,
   input  logic [30:0]        req_box_half_w,
   input  logic [30:0]        req_box_half_h,
   input  logic signed [31:0] req_circle_x,
   input  logic signed [31:0] req_circle_y,
   input  logic [30:0]        req_circle_radius,
   input  logic [31:0]        req_box_collide_mask,
   input  logic [31:0]        req_box_trigger_mask,
   input  logic [31:0]        req_circle_collide_mask,
   input  logic [31:0]        req_circle_trigger_mask,
   input  logic [31:0]        req_pair_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_event_kind,
   output logic signed [17:0] rsp_normal_x,
   output logic signed [17:0] rsp_normal_y,
   output logic [30:0]        rsp_depth,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic [31:0]        rsp_event_mask,
   output logic [31:0]        rsp_tag_out,
   output logic               rsp_last
);
   import acc_pkg::*;

   logic adv;

   // Stage 1: box bounds.
   logic               s1_vld_ff;
   logic signed [31:0] s1_lox_ff, s1_hix_ff, s1_loy_ff, s1_hiy_ff;
   logic signed [31:0] s1_cx_ff, s1_cy_ff;
   logic [30:0]        s1_r_ff;
   logic               s1_coll_ff;
   logic [31:0]        s1_trig_ff, s1_tag_ff;
   logic signed [32:0] bx33, by33, hw33, hh33;

   assign bx33 = {req_box_center_x[31], req_box_center_x};
   assign by33 = {req_box_center_y[31], req_box_center_y};
   assign hw33 = {2'b00, req_box_half_w};
   assign hh33 = {2'b00, req_box_half_h};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_lox_ff  <= sat32(34'(bx33 - hw33));
         s1_hix_ff  <= sat32(34'(bx33 + hw33));
         s1_loy_ff  <= sat32(34'(by33 - hh33));
         s1_hiy_ff  <= sat32(34'(by33 + hh33));
         s1_cx_ff   <= req_circle_x;
         s1_cy_ff   <= req_circle_y;
         s1_r_ff    <= req_circle_radius;
         s1_coll_ff <= (req_box_collide_mask & req_circle_collide_mask & MASK_LOW) != '0;
         s1_trig_ff <= req_box_trigger_mask & req_circle_trigger_mask & MASK_LOW;
         s1_tag_ff  <= req_pair_tag;
      end
   end

   // Stage 2: clamp and offsets.
   logic               s2_vld_ff, s2_far_ff;
   side_type           s2_side_ff;
   logic signed [31:0] px, py;
   logic signed [32:0] ox, oy;
   logic [32:0]        ax, ay;

   always_comb begin
      px = s1_cx_ff;
      if (px > s1_hix_ff) begin
         px = s1_hix_ff;
      end
      if (px < s1_lox_ff) begin
         px = s1_lox_ff;
      end
      py = s1_cy_ff;
      if (py > s1_hiy_ff) begin
         py = s1_hiy_ff;
      end
      if (py < s1_loy_ff) begin
         py = s1_loy_ff;
      end
      ox = {s1_cx_ff[31], s1_cx_ff} - {px[31], px};
      oy = {s1_cy_ff[31], s1_cy_ff} - {py[31], py};
      ax = ox[32] ? 33'(-ox) : 33'(ox);
      ay = oy[32] ? 33'(-oy) : 33'(oy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_far_ff            <= (ax >= {2'b00, s1_r_ff}) || (ay >= {2'b00, s1_r_ff});
         s2_side_ff.neg_x     <= ox[32];
         s2_side_ff.neg_y     <= oy[32];
         s2_side_ff.mag_x     <= ax[30:0];
         s2_side_ff.mag_y     <= ay[30:0];
         s2_side_ff.radius    <= s1_r_ff;
         s2_side_ff.cx        <= s1_cx_ff;
         s2_side_ff.cy        <= s1_cy_ff;
         s2_side_ff.coll      <= s1_coll_ff;
         s2_side_ff.trig_mask <= s1_trig_ff;
         s2_side_ff.tag       <= s1_tag_ff;
      end
   end

   // Stage 3: squares.
   logic        s3_vld_ff, s3_far_ff;
   logic [61:0] s3_sqx_ff, s3_sqy_ff, s3_rr_ff;
   side_type    s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_far_ff  <= s2_far_ff;
         s3_sqx_ff  <= s2_side_ff.mag_x * s2_side_ff.mag_x;
         s3_sqy_ff  <= s2_side_ff.mag_y * s2_side_ff.mag_y;
         s3_rr_ff   <= s2_side_ff.radius * s2_side_ff.radius;
         s3_side_ff <= s2_side_ff;
      end
   end

   logic [62:0] sum_sq;
   logic        contact;

   assign sum_sq  = {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
   assign contact = !s3_far_ff && (sum_sq < {1'b0, s3_rr_ff});

   logic        sq_valid;
   logic [30:0] sq_root;
   side_type    sq_side;

   acc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s3_vld_ff && contact),
      .in_value  (sum_sq[61:0]),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic        dv_valid;
   logic [30:0] dv_root;
   logic [16:0] dv_qx, dv_qy;
   side_type    dv_side;

   acc_ndiv u_ndiv (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_root  (dv_root),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_side  (dv_side)
   );

   // Stage P1: normal, depth and radius products.
   logic               p1_vld_ff, p1_coll_ff;
   logic signed [17:0] p1_nx_ff, p1_ny_ff;
   logic [47:0]        p1_prx_ff, p1_pry_ff;
   logic [30:0]        p1_depth_ff;
   logic signed [31:0] p1_cx_ff, p1_cy_ff;
   logic [31:0]        p1_trig_ff, p1_tag_ff;
   logic [16:0]        qx_eff, qy_eff;
   logic signed [17:0] nx, ny;

   always_comb begin
      qx_eff = (dv_root == '0) ? '0 : dv_qx;
      qy_eff = (dv_root == '0) ? '0 : dv_qy;
      nx     = dv_side.neg_x ? -$signed({1'b0, qx_eff}) : $signed({1'b0, qx_eff});
      ny     = dv_side.neg_y ? -$signed({1'b0, qy_eff}) : $signed({1'b0, qy_eff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_nx_ff    <= nx;
         p1_ny_ff    <= ny;
         p1_prx_ff   <= qx_eff * dv_side.radius;
         p1_pry_ff   <= qy_eff * dv_side.radius;
         p1_depth_ff <= dv_side.radius - dv_root;
         p1_cx_ff    <= dv_side.cx;
         p1_cy_ff    <= dv_side.cy;
         p1_coll_ff  <= dv_side.coll;
         p1_trig_ff  <= dv_side.trig_mask;
         p1_tag_ff   <= dv_side.tag;
      end
   end

   // Stage P2: contact point, into the output register.
   logic [31:0]        tx, ty;
   logic signed [33:0] sx, sy;

   always_comb begin
      tx = 32'((p1_prx_ff + 48'd32768) >> 16);
      ty = 32'((p1_pry_ff + 48'd32768) >> 16);
      sx = {{2{p1_cx_ff[31]}}, p1_cx_ff}
         + (p1_nx_ff[17] ? -$signed({2'b00, tx}) : $signed({2'b00, tx}));
      sy = {{2{p1_cy_ff[31]}}, p1_cy_ff}
         + (p1_ny_ff[17] ? -$signed({2'b00, ty}) : $signed({2'b00, ty}));
   end

   logic               ev_valid_ff, ev_coll_ff, ev_trig_ff;
   logic signed [17:0] ev_nx_ff, ev_ny_ff;
   logic [30:0]        ev_depth_ff;
   logic signed [31:0] ev_ptx_ff, ev_pty_ff;
   logic [31:0]        ev_mask_ff, ev_tag_ff;

   assign adv = !ev_valid_ff || (!rsp_stall && rsp_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
         ev_coll_ff  <= 1'b0;
         ev_trig_ff  <= 1'b0;
      end else if (adv) begin
         ev_valid_ff <= p1_vld_ff && (p1_coll_ff || (p1_trig_ff != '0));
         ev_coll_ff  <= p1_coll_ff;
         ev_trig_ff  <= p1_trig_ff != '0;
      end else if (ev_valid_ff && !rsp_stall) begin
         ev_coll_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ev_nx_ff    <= p1_nx_ff;
         ev_ny_ff    <= p1_ny_ff;
         ev_depth_ff <= p1_depth_ff;
         ev_ptx_ff   <= sat32(sx);
         ev_pty_ff   <= sat32(sy);
         ev_mask_ff  <= p1_trig_ff;
         ev_tag_ff   <= p1_tag_ff;
      end
   end

   assign req_stall      = !adv;
   assign rsp_valid      = ev_valid_ff;
   assign rsp_event_kind = ev_coll_ff ? KIND_COLL : KIND_TRIG;
   assign rsp_normal_x   = ev_coll_ff ? ev_nx_ff : '0;
   assign rsp_normal_y   = ev_coll_ff ? ev_ny_ff : '0;
   assign rsp_depth      = ev_coll_ff ? ev_depth_ff : '0;
   assign rsp_point_x    = ev_coll_ff ? ev_ptx_ff : '0;
   assign rsp_point_y    = ev_coll_ff ? ev_pty_ff : '0;
   assign rsp_event_mask = ev_coll_ff ? '0 : ev_mask_ff;
   assign rsp_tag_out    = ev_tag_ff;
   assign rsp_last       = !(ev_coll_ff && ev_trig_ff);

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last
      |=> rsp_valid && rsp_event_kind == KIND_TRIG && $stable(rsp_tag_out))
      else $error("Trigger event did not follow the collision event of its item.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_TRIG |-> rsp_last && rsp_event_mask != '0)
      else $error("Trigger event is not the last event of its item.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_COLL
      |-> rsp_normal_x <= NORM_MAX && rsp_normal_x >= -NORM_MAX
          && rsp_normal_y <= NORM_MAX && rsp_normal_y >= -NORM_MAX)
      else $error("Contact normal out of unit range.");
`endif

endmodule

`default_nettype wire
